// ----- hdl/cxm_pkg.sv -----
package cxm_pkg;

  localparam int QONE      = 8192;
  localparam int RpmWinLo  = 1500;
  localparam int RpmWinHi  = 5500;
  localparam int RpmDelta  = 750;
  localparam int GainMax   = 4915;

  typedef enum logic [2:0] {
    REG_GAIN_SCALE = 3'd0,
    REG_DEADBAND   = 3'd1,
    REG_HOVER      = 3'd2,
    REG_COMP_EN    = 3'd3,
    REG_THR_LIMIT  = 3'd4,
    REG_LAG_COS    = 3'd5,
    REG_LAG_SIN    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_DEADBAND = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_DISABLED = 2'd3
  } comp_status_t;

  // carried around the gain divider
  typedef struct packed {
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    comp_status_t       status;
    logic               gpos;
    logic signed [19:0] ccw;
    logic signed [19:0] cw;
    logic               lo;
    logic               hi;
    logic               lyaw;
  } pre_t;

  // carried around the square root and the normalizing dividers
  typedef struct packed {
    logic signed [18:0] roll;
    logic signed [18:0] pitch;
    comp_status_t       status;
    logic signed [14:0] gain;
    logic signed [15:0] ccw;
    logic signed [15:0] cw;
    logic               lo;
    logic               hi;
    logic               lyaw;
    logic               lrp;
  } nrm_t;

endpackage

// ----- hdl/cxm_delay.sv -----
module cxm_delay #(
  parameter int  DEPTH = 1,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  T     in_data,
  output logic out_valid,
  output T     out_data
);

  logic [DEPTH-1:0] vld;
  T                 dat [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      for (int i = DEPTH - 1; i > 0; i--) vld[i] <= vld[i-1];
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = DEPTH - 1; i > 0; i--) dat[i] <= dat[i-1];
      dat[0] <= in_data;
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = dat[DEPTH-1];

endmodule

// ----- hdl/cxm_div.sv -----
// Restoring divider, one quotient bit per stage. Needs num < den << QW.
module cxm_div #(
  parameter int NW = 25,
  parameter int DW = 12,
  parameter int QW = 14
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [WW-1:0] r_in;
    logic [WW-1:0] trial;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    if (s == 0) begin : g_first
      assign r_in = WW'(num);
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = WW'(rem_r[s-1]);
      assign d_in = den_r[s-1];
      assign q_in = quo_r[s-1];
    end
    assign trial = r_in - (WW'(d_in) << (QW - 1 - s));
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= d_in;
        if (trial[WW-1]) begin
          rem_r[s] <= NW'(r_in);
          quo_r[s] <= q_in;
        end else begin
          rem_r[s] <= NW'(trial);
          quo_r[s] <= q_in | (QW'(1) << (QW - 1 - s));
        end
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// ----- hdl/cxm_sqrt.sv -----
// Integer square root, floor, one root bit per stage.
module cxm_sqrt #(
  parameter int VW = 36
) (
  input  logic             clk,
  input  logic             en,
  input  logic [VW-1:0]    val,
  output logic [VW/2-1:0]  root
);

  localparam int RW = VW / 2;
  localparam int WW = VW + 1;

  logic [VW-1:0] rem_r [RW];
  logic [RW-1:0] rt_r  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_st
    localparam int B = RW - 1 - s;
    logic [WW-1:0] r_in;
    logic [RW-1:0] q_in;
    logic [WW-1:0] step;
    logic [WW-1:0] trial;
    if (s == 0) begin : g_first
      assign r_in = WW'(val);
      assign q_in = '0;
    end else begin : g_next
      assign r_in = WW'(rem_r[s-1]);
      assign q_in = rt_r[s-1];
    end
    // (q + 2^B)^2 - q^2 = q * 2^(B+1) + 2^(2B)
    assign step  = (WW'(q_in) << (B + 1)) | (WW'(1) << (2 * B));
    assign trial = r_in - step;
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial[WW-1]) begin
          rem_r[s] <= VW'(r_in);
          rt_r[s]  <= q_in;
        end else begin
          rem_r[s] <= VW'(trial);
          rt_r[s]  <= q_in | (RW'(1) << B);
        end
      end
    end
  end

  assign root = rt_r[RW-1];

endmodule

// ----- hdl/coax_rotor_mixer_unit.sv -----
// Coaxial rotor mixer. Throughput: one item per cycle unless m_tready stalls;
// the 14-stage gain divider, the 18-stage square root and the 14-stage
// normalizing dividers are fully pipelined.
// A stall on m_tready freezes the whole pipeline; nothing is dropped.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
module coax_rotor_mixer_unit (
  input  logic         clk,
  input  logic         rst,
  // roll_demand, roll_feedfwd, pitch_demand, pitch_feedfwd, yaw_demand,
  // yaw_feedfwd, throttle_demand (16b each), aft_rpm (14b), 2b pad
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,
  // servo_a(15) servo_b(15) thrust_ccw(16) thrust_cw(16) rpm_comp_gain(15)
  // rpm_comp_status(2) limit_throttle_low limit_throttle_high
  // limit_roll_pitch limit_yaw, 5b pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [87:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [14:0]  cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers, range-limited fields saturated on write
  // ---------------------------------------------------------------
  logic [12:0]        gain_scale;
  logic [9:0]         deadband;
  logic [12:0]        hover;
  logic               comp_en;
  logic [13:0]        thr_limit;
  logic signed [14:0] lag_cos;
  logic signed [14:0] lag_sin;

  logic signed [14:0] cfg_s;
  logic signed [14:0] cfg_lag;
  assign cfg_s   = $signed(cfg_data);
  assign cfg_lag = (cfg_s > 15'sd8192) ? 15'sd8192 :
                   (cfg_s < -15'sd8192) ? -15'sd8192 : cfg_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_scale <= '0;
      deadband   <= '0;
      hover      <= 13'd3000;
      comp_en    <= 1'b0;
      thr_limit  <= 14'(cxm_pkg::QONE);
      lag_cos    <= 15'(cxm_pkg::QONE);
      lag_sin    <= '0;
    end else if (cfg_we) begin
      unique case (cxm_pkg::cfg_reg_t'(cfg_index))
        cxm_pkg::REG_GAIN_SCALE:
          gain_scale <= (cfg_data[12:0] > 13'(cxm_pkg::GainMax)) ?
                        13'(cxm_pkg::GainMax) : cfg_data[12:0];
        cxm_pkg::REG_DEADBAND:
          deadband <= (cfg_data[9:0] > 10'(cxm_pkg::RpmDelta)) ?
                      10'(cxm_pkg::RpmDelta) : cfg_data[9:0];
        cxm_pkg::REG_HOVER:     hover   <= cfg_data[12:0];
        cxm_pkg::REG_COMP_EN:   comp_en <= cfg_data[0];
        cxm_pkg::REG_THR_LIMIT:
          thr_limit <= (cfg_data[13:0] > 14'(cxm_pkg::QONE)) ?
                       14'(cxm_pkg::QONE) : cfg_data[13:0];
        cxm_pkg::REG_LAG_COS:   lag_cos <= cfg_lag;
        cxm_pkg::REG_LAG_SIN:   lag_sin <= cfg_lag;
        default: ;
      endcase
    end
  end

  // Global advance: output register empty or being taken.
  logic en;
  logic out_valid;
  assign en       = m_tready || !out_valid;
  assign s_tready = en;

  // ---------------------------------------------------------------
  // Stage 1: feed-forward sums, throttle clamp, RPM window / deadband
  // ---------------------------------------------------------------
  logic signed [16:0] in_roll, in_pitch, in_yaw;
  logic signed [15:0] in_thr;
  logic [13:0]        in_rpm;
  assign in_roll  = 17'($signed(s_tdata[15:0]))   + 17'($signed(s_tdata[31:16]));
  assign in_pitch = 17'($signed(s_tdata[47:32]))  + 17'($signed(s_tdata[63:48]));
  assign in_yaw   = 17'($signed(s_tdata[79:64]))  + 17'($signed(s_tdata[95:80]));
  assign in_thr   = $signed(s_tdata[111:96]);
  assign in_rpm   = s_tdata[125:112];

  logic               thr_lo, thr_hi;
  logic signed [16:0] thr_c;
  logic [13:0]        thr_n;
  assign thr_lo = in_thr <= 16'sd0;
  assign thr_c  = thr_lo ? 17'sd0 : 17'(in_thr);
  assign thr_hi = thr_c >= $signed(17'(thr_limit));
  assign thr_n  = thr_hi ? thr_limit : thr_c[13:0];

  logic signed [15:0] delta;
  logic signed [11:0] d2, db;
  cxm_pkg::comp_status_t st_n;
  logic               gpos_n;
  logic [10:0]        mag_n;
  assign delta = $signed({2'b0, in_rpm}) - $signed({3'b0, hover});
  assign d2 = (delta > 16'sd750) ? 12'sd1500 :
              (delta < -16'sd750) ? -12'sd1500 : 12'(delta <<< 1);
  assign db = $signed({2'b0, deadband});

  always_comb begin
    gpos_n = 1'b0;
    mag_n  = '0;
    if (!comp_en) begin
      st_n = cxm_pkg::ST_DISABLED;
    end else if (in_rpm <= 14'(cxm_pkg::RpmWinLo) || in_rpm >= 14'(cxm_pkg::RpmWinHi)) begin
      st_n = cxm_pkg::ST_OUTSIDE;
    end else if (d2 < -db) begin
      st_n   = cxm_pkg::ST_APPLIED;
      gpos_n = 1'b1;
      mag_n  = 11'(-(d2 + db));
    end else if (d2 > db) begin
      st_n  = cxm_pkg::ST_APPLIED;
      mag_n = 11'(d2 - db);
    end else begin
      st_n = cxm_pkg::ST_DEADBAND;
    end
  end

  logic                  v1;
  logic signed [16:0]    roll1, pitch1, yaw1;
  logic [13:0]           thr1;
  logic                  lo1, hi1, gpos1;
  cxm_pkg::comp_status_t st1;
  logic [10:0]           mag1, den1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll1  <= in_roll;
      pitch1 <= in_pitch;
      yaw1   <= in_yaw;
      thr1   <= thr_n;
      lo1    <= thr_lo;
      hi1    <= thr_hi;
      st1    <= st_n;
      gpos1  <= gpos_n;
      mag1   <= mag_n;
      den1   <= 11'(11'd1500 - 11'(deadband));
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: gain numerator product, yaw headroom split (doubled units)
  // ---------------------------------------------------------------
  logic signed [19:0] t2x, l2x, y20, ay, hmax2, hmin2, ccw_n, cw_n;
  logic               ylo, yhi, lyaw_n;
  assign t2x   = $signed(20'({thr1, 1'b0}));
  assign l2x   = $signed(20'({thr_limit, 1'b0}));
  assign y20   = 20'(yaw1);
  assign ay    = (y20 < 0) ? -y20 : y20;
  assign hmax2 = l2x - t2x - ay;
  assign hmin2 = t2x - ay;

  always_comb begin
    ccw_n  = t2x + y20;
    cw_n   = t2x - y20;
    ylo    = lo1;
    yhi    = hi1;
    lyaw_n = 1'b0;
    if (hmax2 > 0 && hmin2 > 0) begin
      lyaw_n = 1'b0;
    end else if (hmax2 <= 0) begin
      lyaw_n = 1'b1;
      yhi    = 1'b1;
      ccw_n  = t2x + y20 + hmax2;
      cw_n   = t2x - y20 + hmax2;
    end else begin
      lyaw_n = 1'b1;
      ylo    = 1'b1;
      ccw_n  = t2x + y20 - hmin2;
      cw_n   = t2x - y20 - hmin2;
    end
  end

  logic          v2;
  logic [23:0]   num2;
  logic [10:0]   den2;
  cxm_pkg::pre_t pre2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2        <= 24'(mag1 * gain_scale);
      den2        <= den1;
      pre2.roll   <= roll1;
      pre2.pitch  <= pitch1;
      pre2.status <= st1;
      pre2.gpos   <= gpos1;
      pre2.ccw    <= ccw_n;
      pre2.cw     <= cw_n;
      pre2.lo     <= ylo;
      pre2.hi     <= yhi;
      pre2.lyaw   <= lyaw_n;
    end
  end

  // ---------------------------------------------------------------
  // Gain divider: round(num / den) = floor((2 num + den) / (2 den))
  // ---------------------------------------------------------------
  logic [13:0]   gq;
  logic          vg;
  cxm_pkg::pre_t preg;

  cxm_div #(.NW(25), .DW(12), .QW(14)) u_gdiv (
    .clk (clk),
    .en  (en),
    .num ({num2, 1'b0} + 25'(den2)),
    .den ({den2, 1'b0}),
    .quo (gq)
  );

  cxm_delay #(.DEPTH(14), .T(cxm_pkg::pre_t)) u_gdly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_data   (pre2),
    .out_valid (vg),
    .out_data  (preg)
  );

  // ---------------------------------------------------------------
  // M1: signed gain, gain products, thrust rounding and saturation
  // ---------------------------------------------------------------
  logic signed [14:0] gain_n;
  assign gain_n = (preg.status != cxm_pkg::ST_APPLIED) ? 15'sd0 :
                  preg.gpos ? $signed({1'b0, gq}) : -$signed({1'b0, gq});

  // halve, ties away from zero
  logic signed [20:0] ccw_r, cw_r;
  assign ccw_r = (21'(preg.ccw) + ((preg.ccw < 0) ? 21'sd0 : 21'sd1)) >>> 1;
  assign cw_r  = (21'(preg.cw) + ((preg.cw < 0) ? 21'sd0 : 21'sd1)) >>> 1;

  logic               vm1;
  logic signed [31:0] prr, prp;
  cxm_pkg::nrm_t      m1;

  always_ff @(posedge clk) begin
    if (rst) vm1 <= 1'b0;
    else if (en) vm1 <= vg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prr       <= 32'(preg.roll * gain_n);
      prp       <= 32'(preg.pitch * gain_n);
      m1.roll   <= 19'(preg.roll);
      m1.pitch  <= 19'(preg.pitch);
      m1.status <= preg.status;
      m1.gain   <= gain_n;
      m1.ccw    <= (ccw_r > 21'sd32767) ? 16'sh7FFF :
                   (ccw_r < -21'sd32768) ? 16'sh8000 : 16'(ccw_r);
      m1.cw     <= (cw_r > 21'sd32767) ? 16'sh7FFF :
                   (cw_r < -21'sd32768) ? 16'sh8000 : 16'(cw_r);
      m1.lo     <= preg.lo;
      m1.hi     <= preg.hi;
      m1.lyaw   <= preg.lyaw;
      m1.lrp    <= 1'b0;
    end
  end

  // M2: add the rounded correction
  logic signed [32:0] prr_r, prp_r;
  assign prr_r = (33'(prr) + ((prr < 0) ? 33'sd4095 : 33'sd4096)) >>> 13;
  assign prp_r = (33'(prp) + ((prp < 0) ? 33'sd4095 : 33'sd4096)) >>> 13;

  logic          vm2;
  cxm_pkg::nrm_t m2, m2_next;

  always_comb begin
    m2_next       = m1;
    m2_next.roll  = m1.roll + 19'(prr_r);
    m2_next.pitch = m1.pitch + 19'(prp_r);
  end

  always_ff @(posedge clk) begin
    if (rst) vm2 <= 1'b0;
    else if (en) vm2 <= vm1;
  end

  always_ff @(posedge clk) begin
    if (en) m2 <= m2_next;
  end

  // M3: squares
  logic               vm3;
  logic signed [37:0] sqr, sqp;
  cxm_pkg::nrm_t      m3;

  always_ff @(posedge clk) begin
    if (rst) vm3 <= 1'b0;
    else if (en) vm3 <= vm2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3  <= m2;
      sqr <= 38'(m2.roll * m2.roll);
      sqp <= 38'(m2.pitch * m2.pitch);
    end
  end

  // M4: vector length squared and the over-unity test
  logic          vm4;
  logic [35:0]   sum4;
  cxm_pkg::nrm_t m4, m4_next;
  logic [35:0]   sum_n;
  assign sum_n = 36'(sqr) + 36'(sqp);

  always_comb begin
    m4_next     = m3;
    m4_next.lrp = sum_n > 36'(cxm_pkg::QONE * cxm_pkg::QONE);
  end

  always_ff @(posedge clk) begin
    if (rst) vm4 <= 1'b0;
    else if (en) vm4 <= vm3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4   <= m4_next;
      sum4 <= sum_n;
    end
  end

  // ---------------------------------------------------------------
  // Square root of the length squared, payload delayed alongside
  // ---------------------------------------------------------------
  logic [17:0]   len;
  logic          vs;
  cxm_pkg::nrm_t ms;

  cxm_sqrt #(.VW(36)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .val  (sum4),
    .root (len)
  );

  cxm_delay #(.DEPTH(18), .T(cxm_pkg::nrm_t)) u_sdly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vm4),
    .in_data   (m4),
    .out_valid (vs),
    .out_data  (ms)
  );

  // N: divider operands for round(|x| * 8192 / len)
  logic [17:0] mag_p, mag_r;
  assign mag_p = (ms.pitch < 0) ? 18'(-ms.pitch) : 18'(ms.pitch);
  assign mag_r = (ms.roll < 0) ? 18'(-ms.roll) : 18'(ms.roll);

  logic          vn;
  logic [32:0]   nump, numr;
  logic [18:0]   denn;
  cxm_pkg::nrm_t mn;

  always_ff @(posedge clk) begin
    if (rst) vn <= 1'b0;
    else if (en) vn <= vs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mn   <= ms;
      nump <= 33'({mag_p, 14'b0}) + 33'(len);
      numr <= 33'({mag_r, 14'b0}) + 33'(len);
      denn <= {len, 1'b0};
    end
  end

  logic [13:0]   qp, qr;
  logic          vd;
  cxm_pkg::nrm_t md;

  cxm_div #(.NW(33), .DW(19), .QW(14)) u_pdiv (
    .clk (clk),
    .en  (en),
    .num (nump),
    .den (denn),
    .quo (qp)
  );

  cxm_div #(.NW(33), .DW(19), .QW(14)) u_rdiv (
    .clk (clk),
    .en  (en),
    .num (numr),
    .den (denn),
    .quo (qr)
  );

  cxm_delay #(.DEPTH(14), .T(cxm_pkg::nrm_t)) u_ndly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vn),
    .in_data   (mn),
    .out_valid (vd),
    .out_data  (md)
  );

  // P: pick normalized or original components
  logic          vp;
  cxm_pkg::nrm_t mp, mp_next;

  always_comb begin
    mp_next = md;
    if (md.lrp) begin
      mp_next.pitch = (md.pitch < 0) ? -$signed(19'(qp)) : $signed(19'(qp));
      mp_next.roll  = (md.roll < 0) ? -$signed(19'(qr)) : $signed(19'(qr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else if (en) vp <= vd;
  end

  always_ff @(posedge clk) begin
    if (en) mp <= mp_next;
  end

  // R1: lag rotation products
  logic               vr;
  logic signed [33:0] a1, a2, b1, b2;
  cxm_pkg::nrm_t      mr;

  always_ff @(posedge clk) begin
    if (rst) vr <= 1'b0;
    else if (en) vr <= vp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mr <= mp;
      a1 <= 34'(lag_cos * mp.pitch);
      a2 <= 34'(lag_sin * mp.roll);
      b1 <= 34'(lag_cos * mp.roll);
      b2 <= 34'(lag_sin * mp.pitch);
    end
  end

  // R2 / output register: round, clamp to +/-1
  logic signed [34:0] sa_s, sb_s, sa_q, sb_q;
  logic signed [14:0] sa_n, sb_n;
  assign sa_s = 35'(a1) + 35'(a2);
  assign sb_s = 35'(b1) - 35'(b2);
  assign sa_q = (sa_s + ((sa_s < 0) ? 35'sd4095 : 35'sd4096)) >>> 13;
  assign sb_q = (sb_s + ((sb_s < 0) ? 35'sd4095 : 35'sd4096)) >>> 13;
  assign sa_n = (sa_q > 35'sd8192) ? 15'sd8192 :
                (sa_q < -35'sd8192) ? -15'sd8192 : 15'(sa_q);
  assign sb_n = (sb_q > 35'sd8192) ? 15'sd8192 :
                (sb_q < -35'sd8192) ? -15'sd8192 : 15'(sb_q);

  logic signed [14:0] servo_a, servo_b;
  cxm_pkg::nrm_t      mo;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mo      <= mr;
      servo_a <= sa_n;
      servo_b <= sb_n;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, mo.lyaw, mo.lrp, mo.hi, mo.lo, mo.status, mo.gain,
                     mo.cw, mo.ccw, servo_b, servo_a};

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_gain_only_applied: assert property (@(posedge clk) disable iff (rst)
    out_valid && mo.status != cxm_pkg::ST_APPLIED |-> mo.gain == 15'sd0)
    else $error("gain nonzero without compensation");

  a_servo_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> servo_a <= 15'sd8192 && servo_a >= -15'sd8192 &&
                  servo_b <= 15'sd8192 && servo_b >= -15'sd8192)
    else $error("servo outside +/-1");

  a_yaw_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && mo.lyaw |-> mo.lo || mo.hi)
    else $error("yaw limit without throttle limit");

endmodule

// ----- verif/coax_rotor_mixer_checker.sv -----
module coax_rotor_mixer_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [87:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic signed [14:0]    servo_a;
    logic signed [14:0]    servo_b;
    logic signed [15:0]    ccw;
    logic signed [15:0]    cw;
    logic signed [14:0]    gain;
    cxm_pkg::comp_status_t status;
    logic                  lo;
    logic                  hi;
    logic                  lrp;
    logic                  lyaw;
  } mix_out_t;

  longint gain_scale, deadband, hover, comp_en, thr_limit, lag_cos, lag_sin;
  mix_out_t mix_queue[$];

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // nearest, ties away from zero; d > 0
  function automatic longint round_div(longint n, longint d);
    longint m, q;
    m = n < 0 ? -n : n;
    q = (2 * m + d) / (2 * d);
    return n < 0 ? -q : q;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic mix_out_t mix_predict(logic [127:0] d);
    longint roll, pitch, yaw, thr, rpm, gain, d2, den, sum, len;
    longint ay, hmax2, hmin2, ccw2, cw2;
    mix_out_t r;
    r = '0;
    roll  = longint'($signed(d[15:0]))  + longint'($signed(d[31:16]));
    pitch = longint'($signed(d[47:32])) + longint'($signed(d[63:48]));
    yaw   = longint'($signed(d[79:64])) + longint'($signed(d[95:80]));
    thr   = longint'($signed(d[111:96]));
    rpm   = longint'(d[125:112]);
    gain  = 0;
    if (comp_en == 0) begin
      r.status = cxm_pkg::ST_DISABLED;
    end else if (rpm <= cxm_pkg::RpmWinLo || rpm >= cxm_pkg::RpmWinHi) begin
      r.status = cxm_pkg::ST_OUTSIDE;
    end else begin
      d2 = 2 * clamp64(rpm - hover, -cxm_pkg::RpmDelta, cxm_pkg::RpmDelta);
      den = 2 * cxm_pkg::RpmDelta - deadband;
      if (d2 < -deadband) begin
        gain = round_div(-(d2 + deadband) * gain_scale, den);
        r.status = cxm_pkg::ST_APPLIED;
      end else if (d2 > deadband) begin
        gain = round_div(-(d2 - deadband) * gain_scale, den);
        r.status = cxm_pkg::ST_APPLIED;
      end else begin
        r.status = cxm_pkg::ST_DEADBAND;
      end
      if (r.status == cxm_pkg::ST_APPLIED) begin
        pitch += round_div(pitch * gain, cxm_pkg::QONE);
        roll  += round_div(roll * gain, cxm_pkg::QONE);
      end
    end
    if (thr <= 0) begin
      thr = 0;
      r.lo = 1'b1;
    end
    if (thr >= thr_limit) begin
      thr = thr_limit;
      r.hi = 1'b1;
    end
    sum = pitch * pitch + roll * roll;
    if (sum > longint'(cxm_pkg::QONE) * cxm_pkg::QONE) begin
      len = floor_sqrt(sum);
      pitch = round_div(pitch * cxm_pkg::QONE, len);
      roll  = round_div(roll * cxm_pkg::QONE, len);
      r.lrp = 1'b1;
    end
    r.servo_a = 15'(clamp64(round_div(lag_cos * pitch + lag_sin * roll, cxm_pkg::QONE),
                            -cxm_pkg::QONE, cxm_pkg::QONE));
    r.servo_b = 15'(clamp64(round_div(lag_cos * roll - lag_sin * pitch, cxm_pkg::QONE),
                            -cxm_pkg::QONE, cxm_pkg::QONE));
    ay = yaw < 0 ? -yaw : yaw;
    hmax2 = 2 * thr_limit - (2 * thr + ay);
    hmin2 = 2 * thr - ay;
    ccw2 = 2 * thr + yaw;
    cw2  = 2 * thr - yaw;
    if (!(hmax2 > 0 && hmin2 > 0)) begin
      r.lyaw = 1'b1;
      if (hmax2 <= 0) begin
        r.hi = 1'b1;
        ccw2 += hmax2;
        cw2  += hmax2;
      end else begin
        r.lo = 1'b1;
        ccw2 -= hmin2;
        cw2  -= hmin2;
      end
    end
    r.ccw  = 16'(clamp64(round_div(ccw2, 2), -32768, 32767));
    r.cw   = 16'(clamp64(round_div(cw2, 2), -32768, 32767));
    r.gain = 15'(gain);
    return r;
  endfunction

  function automatic mix_out_t unpack_result(logic [87:0] d);
    mix_out_t r;
    r.servo_a = d[14:0];
    r.servo_b = d[29:15];
    r.ccw     = d[45:30];
    r.cw      = d[61:46];
    r.gain    = d[76:62];
    r.status  = cxm_pkg::comp_status_t'(d[78:77]);
    r.lo      = d[79];
    r.hi      = d[80];
    r.lrp     = d[81];
    r.lyaw    = d[82];
    return r;
  endfunction

  assign pending = mix_queue.size();

  always @(posedge clk) begin
    mix_out_t got, want;
    if (rst) begin
      gain_scale <= 0;
      deadband   <= 0;
      hover      <= 3000;
      comp_en    <= 0;
      thr_limit  <= cxm_pkg::QONE;
      lag_cos    <= cxm_pkg::QONE;
      lag_sin    <= 0;
      errors     <= 0;
      mix_queue.delete();
    end else begin
      // config writes land at this edge; items sampled here use old values,
      // so writes must only happen while idle; the checker does not enforce this
      if (cfg_we) begin
        case (cxm_pkg::cfg_reg_t'(cfg_index))
          cxm_pkg::REG_GAIN_SCALE:
            gain_scale <= clamp64(longint'(cfg_data[12:0]), 0, cxm_pkg::GainMax);
          cxm_pkg::REG_DEADBAND:
            deadband   <= clamp64(longint'(cfg_data[9:0]), 0, cxm_pkg::RpmDelta);
          cxm_pkg::REG_HOVER:     hover   <= longint'(cfg_data[12:0]);
          cxm_pkg::REG_COMP_EN:   comp_en <= longint'(cfg_data[0]);
          cxm_pkg::REG_THR_LIMIT:
            thr_limit  <= clamp64(longint'(cfg_data[13:0]), 0, cxm_pkg::QONE);
          cxm_pkg::REG_LAG_COS:
            lag_cos    <= clamp64(longint'($signed(cfg_data)), -cxm_pkg::QONE,
                                  cxm_pkg::QONE);
          cxm_pkg::REG_LAG_SIN:
            lag_sin    <= clamp64(longint'($signed(cfg_data)), -cxm_pkg::QONE,
                                  cxm_pkg::QONE);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) mix_queue.push_back(mix_predict(s_tdata));
      if (m_tvalid && m_tready) begin
        got = unpack_result(m_tdata);
        if (mix_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          want = mix_queue.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- verif/coax_rotor_mixer_unit_tb.sv -----
module coax_rotor_mixer_unit_tb;

  localparam int Latency = 56;
  localparam longint CycleLimit = 400000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [87:0]  m_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [14:0]  cfg_data;
  int           errors;
  int           pending;
  longint       cycles;
  int           send_idle_pct;   // chance of a sender gap per cycle
  int           recv_stall_pct;  // chance of a receiver stall per cycle

  coax_rotor_mixer_unit u_dut (.*);

  coax_rotor_mixer_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle watchdog; a hang is a failure
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver backpressure, independent of the sender
  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // one write, then cfg_we drops again before returning so back-to-back calls never collide
  task automatic write_reg(cxm_pkg::cfg_reg_t idx, logic [14:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected result arrived, then drain the pipe
  task automatic drain_pipe();
    while (pending != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
  endtask

  // one transfer; valid stays up back to back when no gap is drawn
  task automatic send_item(logic [127:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [127:0] pack_item(logic [15:0] rd, logic [15:0] rf,
                                             logic [15:0] pd, logic [15:0] pf,
                                             logic [15:0] yd, logic [15:0] yf,
                                             logic [15:0] td, logic [13:0] rpm);
    return {2'b00, rpm, td, yf, yd, pf, pd, rf, rd};
  endfunction

  // mostly in-range flight values, sometimes full-scale noise
  function automatic logic [15:0] rand_axis();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(16384) - 8192);
      default: return 16'($urandom_range(4096) - 2048);
    endcase
  endfunction

  function automatic logic [13:0] rand_rpm();
    case ($urandom_range(3))
      0:       return 14'($urandom);
      default: return 14'($urandom_range(5600, 1400));
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) begin
      send_item(pack_item(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                          rand_axis(), rand_axis(),
                          ($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(9000) - 400),
                          rand_rpm()));
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    logic [13:0] rpms [12];
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_we = 0;
    cfg_index = cxm_pkg::REG_GAIN_SCALE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, normalization and yaw headroom at reset settings (compensation disabled)
    send_item(pack_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF, 16'h7FFF, 14'h3FFF));
    send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'h8000, 16'h8000, 16'h8000, 14'h0000));
    send_item(pack_item(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4096, 14'd3000));
    send_item(pack_item(16'd6000, 16'd0, 16'd6000, 16'd0, 16'd1000, 16'd0,
                        16'd4096, 14'd3000));   // vector > 1, normalized
    send_item(pack_item(16'd0, 16'd0, 16'd0, 16'd0, 16'd6000, 16'd0,
                        16'd8000, 14'd3000));   // yaw runs out of top headroom
    send_item(pack_item(16'd0, 16'd0, 16'd0, 16'd0, -16'sd6000, 16'd0,
                        16'd200, 14'd3000));    // yaw runs out of bottom headroom
    s_tvalid <= 1'b0;
    drain_pipe();

    // directed: compensation on, RPM window edges, deadband, both signs
    write_reg(cxm_pkg::REG_COMP_EN, 15'd1);
    write_reg(cxm_pkg::REG_GAIN_SCALE, 15'h7FFF);   // saturates to max
    write_reg(cxm_pkg::REG_DEADBAND, 15'd200);
    write_reg(cxm_pkg::REG_HOVER, 15'd3000);
    write_reg(cxm_pkg::REG_LAG_COS, 15'd7094);
    write_reg(cxm_pkg::REG_LAG_SIN, 15'd4096);
    rpms = '{14'd1500, 14'd1501, 14'd5499, 14'd5500, 14'd3000, 14'd3100,
             14'd2899, 14'd3101, 14'd2000, 14'd4000, 14'd2250, 14'd3750};
    foreach (rpms[i])
      send_item(pack_item(16'd3000, 16'd500, -16'sd2500, 16'd0, 16'd800, 16'd0,
                          16'd4000, rpms[i]));
    s_tvalid <= 1'b0;
    drain_pipe();

    // zero throttle limit: high throttle limit and yaw limit set
    write_reg(cxm_pkg::REG_THR_LIMIT, 15'd0);
    send_item(pack_item(16'd100, 16'd0, 16'd100, 16'd0, 16'd100, 16'd0, 16'd50, 14'd3000));
    s_tvalid <= 1'b0;
    drain_pipe();

    // random phases across register settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      write_reg(cxm_pkg::REG_GAIN_SCALE, (ph == 0) ? 15'd0 : 15'($urandom));
      write_reg(cxm_pkg::REG_DEADBAND,
                (ph == 1) ? 15'd750 : (ph == 2) ? 15'd0 : 15'($urandom));
      write_reg(cxm_pkg::REG_HOVER,
                (ph == 3) ? 15'h1FFF : 15'($urandom_range(5000, 1000)));
      write_reg(cxm_pkg::REG_COMP_EN, (ph == 7) ? 15'd0 : 15'($urandom | 1));
      write_reg(cxm_pkg::REG_THR_LIMIT, (ph == 4) ? 15'h3FFF : 15'($urandom));
      write_reg(cxm_pkg::REG_LAG_COS, (ph == 5) ? 15'h4000 : 15'($urandom));
      write_reg(cxm_pkg::REG_LAG_SIN, (ph == 6) ? 15'h3FFF : 15'($urandom));
      send_random(125);
      drain_pipe();
    end

    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
